@@ hdl/fle_pkg.sv @@
// ----------------------------------------------------------------------------
// fle_pkg
// Types and constants shared by the flag/length frame extractor.
// ----------------------------------------------------------------------------
package fle_pkg;

	localparam int unsigned BYTE_W = 8;

	// The flag value after reset, and the shortest legal frame length.
	localparam logic [BYTE_W-1:0] FLAG_RESET    = 8'd126;
	localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd3;

	// Frame tracking: hunting for a flag, expecting the length byte, in the body.
	typedef enum logic [1:0] {
		ST_HUNT,
		ST_LEN,
		ST_BODY
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              frame_start;
		logic              frame_end;
		logic              frame_abort;
	} result_t;

endpackage

@@ hdl/fle_stream_if.sv @@
// ----------------------------------------------------------------------------
// fle_stream_if
// Valid/ready channels of the frame extractor: received bytes in, marked
// frame bytes out.
// ----------------------------------------------------------------------------
interface fle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fle_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_start;
	logic       frame_end;
	logic       frame_abort;

	modport source (output valid, output frame_byte, output frame_start,
		output frame_end, output frame_abort, input ready);
	modport sink   (input valid, input frame_byte, input frame_start,
		input frame_end, input frame_abort, output ready);
endinterface

@@ hdl/fle_frame_ctrl.sv @@
// ----------------------------------------------------------------------------
// fle_frame_ctrl
// Frame tracking state machine: decides for each byte whether it is part of
// a frame and which start, end and abort marks it carries.
// ----------------------------------------------------------------------------
module fle_frame_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [fle_pkg::BYTE_W-1:0]    byte_s1,
	input  logic [fle_pkg::BYTE_W-1:0]    flag,
	output logic                          emit,
	output fle_pkg::result_t              res
);
	import fle_pkg::*;

	state_t            state_q, state_d;
	logic [BYTE_W-1:0] pos_q, pos_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic              is_flag;
	logic              at_last;

	assign is_flag = (byte_s1 == flag);
	// The position is checked one ahead, so the last byte sits at length-1.
	assign at_last = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			pos_q   <= '0;
			len_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		len_d   = len_q;
		emit    = 1'b0;
		res     = '{frame_byte: byte_s1, frame_start: 1'b0, frame_end: 1'b0,
			frame_abort: 1'b0};
		unique case (state_q)
			ST_HUNT: begin
				if (is_flag) begin
					emit            = 1'b1;
					res.frame_start = 1'b1;
					state_d         = ST_LEN;
				end
			end
			ST_LEN: begin
				emit = 1'b1;
				if (is_flag) begin
					res.frame_start = 1'b1;
					res.frame_abort = 1'b1;
				end else if (byte_s1 < MIN_FRAME_LEN) begin
					res.frame_abort = 1'b1;
					state_d         = ST_HUNT;
				end else begin
					len_d   = byte_s1;
					pos_d   = 8'd2;
					state_d = ST_BODY;
				end
			end
			ST_BODY: begin
				emit = 1'b1;
				if (is_flag) begin
					res.frame_start = 1'b1;
					res.frame_abort = 1'b1;
					state_d         = ST_LEN;
				end else if (at_last) begin
					res.frame_end = 1'b1;
					state_d       = ST_HUNT;
				end else begin
					pos_d = pos_q + 8'd1;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// Inside the body the next position never reaches past the frame length.
	a_body_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BODY |-> ({1'b0, pos_q} + 9'd1) <= {1'b0, len_q})
		else $error("frame position ran past the length");

	// A completed frame always sends the tracker back to hunting.
	a_end_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && res.frame_end |=> state_q == ST_HUNT)
		else $error("tracker did not return to hunting after a frame end");

	// A start mark, alone or with an abort, only comes on the flag byte, never with an end.
	a_flag_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && res.frame_start |-> is_flag && !res.frame_end)
		else $error("frame start marked on a byte that is not the flag");
`endif

endmodule

@@ hdl/flag_length_frame_extractor.sv @@
// An accepted byte goes from the input register via the tracker to the output register.
// Throughput: one byte per cycle unless tx stalls; one state update per byte.
// The input register and the output register each hold one byte; a stall on tx
// holds rx only once the input register is full, and no byte is lost in a stall.
// Reset (arst_n low) empties both registers, sets hunting and restores flag 126.
// ----------------------------------------------------------------------------
// flag_length_frame_extractor
// Cut-through frame finder for a flag/length framed byte stream.
// ----------------------------------------------------------------------------
module flag_length_frame_extractor (
	input  logic                          clk,
	input  logic                          arst_n,
	fle_byte_if.sink                      rx,
	fle_frame_if.source                   tx,
	input  logic                          cfg_we,
	input  logic [fle_pkg::BYTE_W-1:0]    cfg_wdata
);
	import fle_pkg::*;

	logic [BYTE_W-1:0] flag_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           out_q;
	logic              advance;
	logic              step;
	logic              emit;
	result_t           res;

	// The output register can take a new result when empty or being drained.
	assign advance  = !out_valid_q || tx.ready;
	assign step     = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= FLAG_RESET;
		end else if (cfg_we) begin
			flag_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	fle_frame_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.flag    (flag_q),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= res;
		end
	end

	assign tx.valid       = out_valid_q;
	assign tx.frame_byte  = out_q.frame_byte;
	assign tx.frame_start = out_q.frame_start;
	assign tx.frame_end   = out_q.frame_end;
	assign tx.frame_abort = out_q.frame_abort;

`ifndef NO_ASSERTIONS
	// A held result must not be overwritten while the sink stalls.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tx.ready |=> out_valid_q && $stable(out_q))
		else $error("pending result changed during a stall");

	// A byte waiting in the input register is consumed whenever the output frees.
	a_input_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |-> rx.ready)
		else $error("input register stuck although the output is empty");

	// An end mark never comes with a start or an abort.
	a_mark_mix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.frame_end |-> !out_q.frame_start && !out_q.frame_abort)
		else $error("frame end combined with start or abort");
`endif

endmodule
